[src/assert_macros.svh]
// Assertion macros used by the clip region stack RTL.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an implication holds on every clock edge out of reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that a condition holds in the cycle after another.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[src/crs_pkg.sv]
// Types and codes for the clip region stack.
// Depends on nothing.
package crs_pkg;
  typedef enum logic [1:0] {CMD_PUSH = 2'd0, CMD_POP = 2'd1, CMD_CLEAR = 2'd2,
                            CMD_READ = 2'd3} cmd_t;
  typedef enum logic [3:0] {
    ST_PUSHED = 4'd0, ST_MERGED = 4'd1, ST_SKIPPED = 4'd2, ST_FULL = 4'd3,
    ST_FRAMES_FULL = 4'd4, ST_POPPED = 4'd5, ST_POP_EMPTY = 4'd6,
    ST_CLEARED = 4'd7, ST_READ_OK = 4'd8, ST_READ_INVALID = 4'd9
  } status_t;
  typedef enum logic [1:0] {KIND_PUSHED = 2'd0, KIND_MERGED = 2'd1,
                            KIND_SKIPPED = 2'd2} kind_t;
  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN, S_MERGE_RD, S_MERGE, S_POP_RD, S_POP,
    S_READ_RD, S_READ, S_DONE
  } state_t;
  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic [18:0] w;
    logic [18:0] h;
    logic signed [19:0] r;
  } region_t;
endpackage

[src/clip_region_stack_top.sv]
// Clip region stack: region memory, frame memory and a walking sequencer.
// Depends on crs_pkg and assert_macros.svh.
//
// Usage: drive cmd and the rect fields with start high while busy is low; the
// word is taken at that edge. busy rises the next cycle and stays high until
// done pulses with status, active_count and the out fields for one cycle.
// The receiver cannot stall; each word must be taken when done is high.
// Commands run in sequenced steps: clear finishes directly, read reads the
// region RAM, pop reads the frame memory and then the region RAM, and push
// runs a redundancy scan over the active regions and then a merge walk, each
// step reading the registered-read region RAM, so push time grows with the
// active region count. One command is in flight at a time.
// max_slots is written on cfg_valid/cfg_ready (ready is high when idle and start is low).
// Reset empties the region set and the frame stack and sets max_slots to 8;
// memories hold no reset value and are read only where written.
module clip_region_stack_top #(
  parameter int SLOTS  = 8,
  parameter int FRAMES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic signed [19:0] rect_x,
  input  logic signed [19:0] rect_y,
  input  logic [18:0] rect_w,
  input  logic [18:0] rect_h,
  input  logic signed [19:0] corner_radius,
  input  logic [2:0]  read_slot,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output logic        done,
  output logic [3:0]  status,
  output logic [3:0]  active_count,
  output logic signed [19:0] out_x,
  output logic signed [19:0] out_y,
  output logic [18:0] out_w,
  output logic [18:0] out_h,
  output logic signed [19:0] out_radius
);
  import crs_pkg::*;
  `include "assert_macros.svh"

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int NW = $clog2(FRAMES + 1);

  typedef struct packed {
    logic [1:0] kind;
    logic [SW-1:0] slot;
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic [18:0] w;
    logic [18:0] h;
  } frame_t;

  region_t reg_mem [SLOTS];
  frame_t  frm_mem [FRAMES];

  state_t state, state_next;
  logic [3:0] max_slots;
  logic [CW-1:0] count;
  logic [NW-1:0] fcount;
  logic [CW-1:0] idx;
  region_t clip;
  logic signed [21:0] sx, sy, sx1, sy1;
  logic [2:0] rslot;
  region_t rd_reg;
  frame_t rd_frm;
  logic [3:0] st_q;
  region_t out_q;

  logic reg_we;
  logic [SW-1:0] reg_wa, reg_ra;
  region_t reg_wd;
  logic frm_we;
  logic [FW-1:0] frm_wa, frm_ra;
  frame_t frm_wd;

  always_ff @(posedge clk) begin
    if (reg_we) reg_mem[reg_wa] <= reg_wd;
    rd_reg <= reg_mem[reg_ra];
    if (frm_we) frm_mem[frm_wa] <= frm_wd;
    rd_frm <= frm_mem[frm_ra];
  end

  logic signed [21:0] inset;
  logic signed [21:0] gx1, gy1, cx1, cy1, mx0, my0, mx1, my1, mw, mh;
  logic inside_hit, frames_full, is_rect_g;
  logic [CW-1:0] limit;

  always_comb begin
    inset = (clip.r > 0) ? 22'(clip.r) + 22'sd8 : 22'sd8;
    gx1 = 22'(rd_reg.x) + 22'($signed({1'b0, rd_reg.w}));
    gy1 = 22'(rd_reg.y) + 22'($signed({1'b0, rd_reg.h}));
    cx1 = 22'(clip.x) + 22'($signed({1'b0, clip.w}));
    cy1 = 22'(clip.y) + 22'($signed({1'b0, clip.h}));
    inside_hit = (22'(rd_reg.x) >= sx) && (22'(rd_reg.y) >= sy) &&
                 (gx1 <= sx1) && (gy1 <= sy1);
    mx0 = (22'(rd_reg.x) > 22'(clip.x)) ? 22'(rd_reg.x) : 22'(clip.x);
    my0 = (22'(rd_reg.y) > 22'(clip.y)) ? 22'(rd_reg.y) : 22'(clip.y);
    mx1 = (gx1 < cx1) ? gx1 : cx1;
    my1 = (gy1 < cy1) ? gy1 : cy1;
    mw = mx1 - mx0;
    mh = my1 - my0;
    if (mw < 0) mw = '0;
    if (mh < 0) mh = '0;
    is_rect_g = !(rd_reg.r > 0);
    frames_full = (fcount >= NW'(FRAMES));
    limit = (32'(max_slots) < SLOTS) ? CW'(max_slots) : CW'(SLOTS);
  end

  logic signed [22:0] sw_full, sh_full;
  always_comb begin
    sw_full = 23'($signed({1'b0, clip.w})) - 23'(inset <<< 1);
    sh_full = 23'($signed({1'b0, clip.h})) - 23'(inset <<< 1);
  end

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_slots <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      max_slots <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  logic [CW-1:0] count_next, idx_next;
  logic [NW-1:0] fcount_next;
  logic [3:0] st_next;
  region_t out_next;

  always_comb begin
    state_next = state;
    count_next = count;
    fcount_next = fcount;
    idx_next = idx;
    st_next = st_q;
    out_next = out_q;
    reg_we = 1'b0;
    reg_wa = '0;
    reg_wd = clip;
    reg_ra = idx[SW-1:0];
    frm_we = 1'b0;
    frm_wa = fcount[FW-1:0];
    frm_wd = '0;
    frm_ra = FW'(fcount - NW'(1));
    unique case (state)
      S_IDLE: begin
        if (start) begin
          idx_next = '0;
          out_next = '0;
          unique case (cmd)
            CMD_PUSH:  state_next = S_SCAN_RD;
            CMD_POP:   state_next = S_POP_RD;
            CMD_CLEAR: begin
              count_next = '0;
              fcount_next = '0;
              st_next = ST_CLEARED;
              state_next = S_DONE;
            end
            default:   state_next = S_READ_RD;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (idx >= count) begin
          idx_next = '0;
          state_next = (clip.r > 0) ? S_MERGE : S_MERGE_RD;
          if (clip.r > 0) idx_next = count;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (inside_hit) begin
          if (frames_full) begin
            st_next = ST_FRAMES_FULL;
          end else begin
            frm_we = 1'b1;
            frm_wd.kind = KIND_SKIPPED;
            fcount_next = fcount + NW'(1);
            st_next = ST_SKIPPED;
          end
          state_next = S_DONE;
        end else begin
          idx_next = idx + CW'(1);
          state_next = S_SCAN_RD;
        end
      end
      S_MERGE_RD: begin
        state_next = S_MERGE;
      end
      S_MERGE: begin
        if (idx < count && is_rect_g && clip.r <= 0) begin
          if (frames_full) begin
            st_next = ST_FRAMES_FULL;
          end else begin
            frm_we = 1'b1;
            frm_wd.kind = KIND_MERGED;
            frm_wd.slot = idx[SW-1:0];
            frm_wd.x = rd_reg.x;
            frm_wd.y = rd_reg.y;
            frm_wd.w = rd_reg.w;
            frm_wd.h = rd_reg.h;
            fcount_next = fcount + NW'(1);
            reg_we = 1'b1;
            reg_wa = idx[SW-1:0];
            reg_wd = rd_reg;
            reg_wd.x = 20'(mx0);
            reg_wd.y = 20'(my0);
            reg_wd.w = 19'(mw);
            reg_wd.h = 19'(mh);
            st_next = ST_MERGED;
          end
          state_next = S_DONE;
        end else if (idx < count && clip.r <= 0) begin
          idx_next = idx + CW'(1);
          reg_ra = SW'(idx + CW'(1));
          state_next = S_MERGE;
        end else begin
          if (count >= limit) begin
            st_next = ST_FULL;
          end else if (frames_full) begin
            st_next = ST_FRAMES_FULL;
          end else begin
            frm_we = 1'b1;
            frm_wd.kind = KIND_PUSHED;
            frm_wd.slot = count[SW-1:0];
            fcount_next = fcount + NW'(1);
            reg_we = 1'b1;
            reg_wa = count[SW-1:0];
            reg_wd = clip;
            count_next = count + CW'(1);
            st_next = ST_PUSHED;
          end
          state_next = S_DONE;
        end
      end
      S_POP_RD: begin
        if (fcount == '0) begin
          st_next = ST_POP_EMPTY;
          state_next = S_DONE;
        end else begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        fcount_next = fcount - NW'(1);
        if (rd_frm.kind == KIND_PUSHED) begin
          if (count > '0) count_next = count - CW'(1);
        end else if (rd_frm.kind == KIND_MERGED) begin
          state_next = S_DONE;
        end
        state_next = S_READ;
        st_next = ST_POPPED;
      end
      S_READ_RD: begin
        reg_ra = SW'(rslot);
        if (CW'(rslot) < count && 32'(rslot) < SLOTS) begin
          state_next = S_READ;
          st_next = ST_READ_OK;
        end else begin
          st_next = ST_READ_INVALID;
          state_next = S_DONE;
        end
      end
      S_READ: begin
        if (st_q == ST_POPPED) begin
          if (rd_frm.kind == KIND_MERGED) begin
            reg_we = 1'b1;
            reg_wa = rd_frm.slot;
            reg_wd = rd_reg;
            reg_wd.x = rd_frm.x;
            reg_wd.y = rd_frm.y;
            reg_wd.w = rd_frm.w;
            reg_wd.h = rd_frm.h;
          end
        end else begin
          out_next = rd_reg;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_POP) reg_ra = rd_frm.slot;
    if (state == S_MERGE_RD) reg_ra = idx[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      fcount <= '0;
    end else begin
      count <= count_next;
      fcount <= fcount_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    st_q <= st_next;
    out_q <= out_next;
    if (state == S_IDLE && start) begin
      rslot <= read_slot;
      clip.x <= rect_x;
      clip.y <= rect_y;
      clip.w <= rect_w;
      clip.h <= rect_h;
      clip.r <= corner_radius;
    end
    if (state == S_SCAN_RD && idx == '0) begin
      sx <= 22'(clip.x) + inset;
      sy <= 22'(clip.y) + inset;
      sx1 <= 22'(clip.x) + inset + ((sw_full < 0) ? 22'sd0 : 22'(sw_full));
      sy1 <= 22'(clip.y) + inset + ((sh_full < 0) ? 22'sd0 : 22'(sh_full));
    end
  end

  assign done = (state == S_DONE);
  assign status = st_q;
  assign active_count = 4'(count);
  assign out_x = out_q.x;
  assign out_y = out_q.y;
  assign out_w = out_q.w;
  assign out_h = out_q.h;
  assign out_radius = out_q.r;

  `ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CW'(SLOTS))
  `ASSERT_IMPL(a_frames_bound, clk, rst, 1'b1, fcount <= NW'(FRAMES))
  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `ASSERT_NEXT(a_done_idle, clk, rst, done, !busy)
endmodule

[tb/clip_region_stack_top_test.sv]
// Self-checking bench for clip_region_stack_top: directed table, then random words.
// Depends on crs_pkg and the clip_region_stack_top RTL.
`timescale 1ns / 1ps
module clip_region_stack_top_test;
  import crs_pkg::*;

  typedef struct {
    logic [1:0] c;
    logic signed [19:0] x, y;
    logic [18:0] w, h;
    logic signed [19:0] r;
    logic [2:0] s;
    bit fixed;
    logic [3:0] st, cnt;
  } row_t;

  typedef struct {
    logic [3:0] st, cnt;
    logic signed [19:0] x, y;
    logic [18:0] w, h;
    logic signed [19:0] r;
  } res_t;

  typedef struct {
    longint x, y, w, h, r;
  } rgn_t;

  typedef struct {
    kind_t k;
    int slot;
    longint x, y, w, h;
  } frm_t;

  logic clk, rst, start, cfg_valid;
  logic [1:0] cmd;
  logic signed [19:0] rect_x, rect_y, corner_radius;
  logic [18:0] rect_w, rect_h;
  logic [2:0] read_slot;
  logic [3:0] cfg_data;
  logic busy, cfg_ready, done;
  logic [3:0] status, active_count;
  logic signed [19:0] out_x, out_y, out_radius;
  logic [18:0] out_w, out_h;

  rgn_t rgns[8];
  frm_t frms[64];
  int rgn_cnt, frm_cnt, slot_limit;
  res_t pending[$];
  int errors, words, idle_pct;
  row_t dir[$];

  clip_region_stack_top u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void add_row(row_t r);
    dir.insert(dir.size(), r);
  endfunction

  function automatic bit contains(rgn_t o, rgn_t i);
    return i.x >= o.x && i.y >= o.y && i.x + i.w <= o.x + o.w && i.y + i.h <= o.y + o.h;
  endfunction

  function automatic status_t push_region(rgn_t c);
    longint ins;
    rgn_t sf;
    int lim;
    lim = slot_limit < 8 ? slot_limit : 8;
    ins = (c.r > 0 ? c.r : 0) + 8;
    sf.x = c.x + ins; sf.y = c.y + ins; sf.r = 0;
    sf.w = c.w - 2 * ins; if (sf.w < 0) sf.w = 0;
    sf.h = c.h - 2 * ins; if (sf.h < 0) sf.h = 0;
    for (int i = 0; i < rgn_cnt; i++)
      if (contains(sf, rgns[i])) begin
        if (frm_cnt >= 64) return ST_FRAMES_FULL;
        frms[frm_cnt] = '{KIND_SKIPPED, 0, 0, 0, 0, 0};
        frm_cnt++;
        return ST_SKIPPED;
      end
    if (c.r <= 0)
      for (int i = 0; i < rgn_cnt; i++) begin
        longint x1, y1;
        if (rgns[i].r > 0) continue;
        if (frm_cnt >= 64) return ST_FRAMES_FULL;
        frms[frm_cnt] = '{KIND_MERGED, i, rgns[i].x, rgns[i].y, rgns[i].w, rgns[i].h};
        frm_cnt++;
        x1 = rgns[i].x + rgns[i].w < c.x + c.w ? rgns[i].x + rgns[i].w : c.x + c.w;
        y1 = rgns[i].y + rgns[i].h < c.y + c.h ? rgns[i].y + rgns[i].h : c.y + c.h;
        if (c.x > rgns[i].x) rgns[i].x = c.x;
        if (c.y > rgns[i].y) rgns[i].y = c.y;
        rgns[i].w = x1 - rgns[i].x > 0 ? x1 - rgns[i].x : 0;
        rgns[i].h = y1 - rgns[i].y > 0 ? y1 - rgns[i].y : 0;
        return ST_MERGED;
      end
    if (rgn_cnt >= lim) return ST_FULL;
    if (frm_cnt >= 64) return ST_FRAMES_FULL;
    frms[frm_cnt] = '{KIND_PUSHED, rgn_cnt, 0, 0, 0, 0};
    frm_cnt++;
    rgns[rgn_cnt] = c;
    rgn_cnt++;
    return ST_PUSHED;
  endfunction

  function automatic res_t predict_word(row_t w);
    res_t o;
    rgn_t c;
    o = '{default: '0};
    case (cmd_t'(w.c))
      CMD_PUSH: begin
        c = '{w.x, w.y, w.w, w.h, w.r};
        o.st = push_region(c);
      end
      CMD_POP: begin
        if (frm_cnt == 0) o.st = ST_POP_EMPTY;
        else begin
          frm_cnt--;
          if (frms[frm_cnt].k == KIND_PUSHED) begin
            if (rgn_cnt > 0) rgn_cnt--;
          end else if (frms[frm_cnt].k == KIND_MERGED) begin
            rgns[frms[frm_cnt].slot].x = frms[frm_cnt].x;
            rgns[frms[frm_cnt].slot].y = frms[frm_cnt].y;
            rgns[frms[frm_cnt].slot].w = frms[frm_cnt].w;
            rgns[frms[frm_cnt].slot].h = frms[frm_cnt].h;
          end
          o.st = ST_POPPED;
        end
      end
      CMD_CLEAR: begin
        rgn_cnt = 0; frm_cnt = 0; o.st = ST_CLEARED;
      end
      default: begin
        if (w.s < rgn_cnt) begin
          o.st = ST_READ_OK;
          o.x = rgns[w.s].x; o.y = rgns[w.s].y; o.w = rgns[w.s].w;
          o.h = rgns[w.s].h; o.r = rgns[w.s].r;
        end else o.st = ST_READ_INVALID;
      end
    endcase
    o.cnt = rgn_cnt[3:0];
    return o;
  endfunction

  always @(posedge clk) begin
    res_t e;
    if (!rst && done) begin
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected word status=%0d", $time, status);
      end else begin
        e = pending.pop_front();
        if (status !== e.st || active_count !== e.cnt || out_x !== e.x || out_y !== e.y ||
            out_w !== e.w || out_h !== e.h || out_radius !== e.r) begin
          errors++;
          $display("%0t: expected st=%0d cnt=%0d x=%0d y=%0d w=%0d h=%0d r=%0d", $time,
                   e.st, e.cnt, e.x, e.y, e.w, e.h, e.r);
          $display("%0t: actual   st=%0d cnt=%0d x=%0d y=%0d w=%0d h=%0d r=%0d", $time,
                   status, active_count, out_x, out_y, out_w, out_h, out_radius);
        end
      end
    end
  end

  task automatic send(row_t w);
    res_t e;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    cmd <= w.c; rect_x <= w.x; rect_y <= w.y; rect_w <= w.w; rect_h <= w.h;
    corner_radius <= w.r; read_slot <= w.s; start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    e = predict_word(w);
    if (w.fixed && (e.st !== w.st || e.cnt !== w.cnt)) begin
      errors++;
      $display("%0t: table expected st=%0d cnt=%0d, model gives st=%0d cnt=%0d", $time,
               w.st, w.cnt, e.st, e.cnt);
    end
    pending.insert(pending.size(), e);
    words++;
    @(negedge clk);
  endtask

  task automatic drain();
    int n;
    n = 0;
    start <= 0;
    while (pending.size() != 0 && n < 10000) begin
      @(negedge clk);
      n++;
    end
    repeat (30) @(negedge clk);
  endtask

  task automatic set_limit(logic [3:0] v);
    drain();
    cfg_data <= v; cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    slot_limit = v;
  endtask

  function automatic row_t rnd_word();
    row_t w;
    int p;
    w = '{default: '0};
    p = $urandom_range(99);
    w.c = p < 55 ? CMD_PUSH : p < 78 ? CMD_POP : p < 81 ? CMD_CLEAR : CMD_READ;
    w.s = 3'($urandom_range(7));
    if ($urandom_range(9) == 0) begin
      w.x = 20'($urandom); w.y = 20'($urandom); w.w = 19'($urandom);
      w.h = 19'($urandom); w.r = 20'($urandom);
    end else begin
      w.x = 20'($signed($urandom_range(4000)) - 2000);
      w.y = 20'($signed($urandom_range(4000)) - 2000);
      w.w = 19'($urandom_range(4000));
      w.h = 19'($urandom_range(4000));
      w.r = 20'($urandom_range(2) == 0 ? $signed($urandom_range(300)) :
                -$signed($urandom_range(50)));
    end
    return w;
  endfunction

  initial begin
    errors = 0; words = 0; idle_pct = 0;
    start = 0; cfg_valid = 0; cfg_data = 8; cmd = CMD_PUSH;
    rect_x = 0; rect_y = 0; rect_w = 0; rect_h = 0; corner_radius = 0; read_slot = 0;
    rgn_cnt = 0; frm_cnt = 0; slot_limit = 8;
    rst = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    add_row('{CMD_POP, 0, 0, 0, 0, 0, 0, 1, ST_POP_EMPTY, 4'd0});
    add_row('{CMD_READ, 0, 0, 0, 0, 0, 0, 1, ST_READ_INVALID, 4'd0});
    add_row('{CMD_PUSH, -20'sd524288, -20'sd524288, 19'h7FFFF, 19'h7FFFF,
              20'sd0, 0, 1, ST_PUSHED, 4'd1});
    add_row('{CMD_PUSH, 100, 100, 1000, 1000, -20'sd524288, 0, 0, 0, 0});
    add_row('{CMD_PUSH, 20'sd524287, 20'sd524287, 19'h7FFFF, 19'h7FFFF,
              20'sd524287, 7, 0, 0, 0});
    add_row('{CMD_PUSH, -20'sd524288, -20'sd524288, 19'h7FFFF, 19'h7FFFF,
              20'sd16, 0, 0, 0, 0});
    add_row('{CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    add_row('{CMD_READ, 0, 0, 0, 0, 0, 1, 0, 0, 0});
    add_row('{CMD_READ, 0, 0, 0, 0, 0, 7, 0, 0, 0});
    add_row('{CMD_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    add_row('{CMD_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    add_row('{CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    add_row('{CMD_CLEAR, 0, 0, 0, 0, 0, 0, 1, ST_CLEARED, 4'd0});
    foreach (dir[i]) send(dir[i]);

    set_limit(4'd0);
    send('{CMD_PUSH, 0, 0, 100, 100, 20'sd5, 0, 1, ST_FULL, 4'd0});
    set_limit(4'd15);
    send('{CMD_PUSH, 0, 0, 100, 100, 20'sd5, 0, 1, ST_PUSHED, 4'd1});
    for (int i = 0; i < 66; i++)
      send('{CMD_PUSH, -1000, -1000, 4000, 4000, 20'sd0, 0, 0, 0, 0});
    send('{CMD_CLEAR, 0, 0, 0, 0, 0, 0, 1, ST_CLEARED, 4'd0});

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 53;
        2: idle_pct = 0;
        default: idle_pct = 28;
      endcase
      set_limit(ph == 0 ? 4'd8 : ph == 1 ? 4'd1 : ph == 5 ? 4'd15 : 4'($urandom_range(1, 8)));
      for (int i = 0; i < 90; i++) send(rnd_word());
      drain();
    end
    for (int i = 0; i < 60; i++) send(rnd_word());

    drain();
    $display("Ran %0d words through push, merge, skip, pop, clear and read;", words);
    $display("slot limits 0..15, frame stack overflow, random sender gaps.");
    if (errors == 0 && pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
